// ----- rtl/aprc_pkg.sv -----
// Package for the aging page replacement core: sizes, register indexes,
// controller states and the structs shared by the top level and the frame cells.
// No dependencies.
`timescale 1ns / 1ps
package aprc_pkg;

   localparam int NUM_FRAMES = 64;
   localparam int NUM_PAGES  = 1024;
   localparam int FRAME_W    = $clog2(NUM_FRAMES);
   localparam int COUNT_W    = $clog2(NUM_FRAMES + 1);
   localparam int PAGE_W     = $clog2(NUM_PAGES);
   localparam int CLEAR_W    = $clog2(NUM_PAGES + 1);
   localparam int AGE_W      = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_INTERVAL = 1'b1;

   localparam logic [6:0]  FRAMES_RESET = 7'd64;
   localparam logic [15:0] TICK_RESET   = 16'd100;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOOK,
      ST_SEARCH,
      ST_PLACE,
      ST_WRITE,
      ST_DONE
   } state_type;

   // Running best candidate handed from cell to cell.
   typedef struct packed {
      logic               found_free;
      logic [FRAME_W-1:0] idx;
      logic [AGE_W:0]     age;
      logic [PAGE_W-1:0]  owner;
   } chain_type;

   // Commands broadcast from the controller to every cell.
   typedef struct packed {
      logic               tick;
      logic               set_ref;
      logic               load;
      logic               zero_age;
      logic [FRAME_W-1:0] frame;
      logic [PAGE_W-1:0]  page;
      logic [COUNT_W-1:0] n_active;
   } cell_ctl_type;

endpackage

// ----- rtl/aprc_cell.sv -----
// One page frame cell: age, referenced and occupied bits, owner page, and
// one registered stage of the victim search chain. Depends on aprc_pkg.
`timescale 1ns / 1ps
module aprc_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [aprc_pkg::FRAME_W-1:0] cell_idx,
   input  aprc_pkg::cell_ctl_type      ctl,
   input  aprc_pkg::chain_type         chain_in,
   output aprc_pkg::chain_type         chain_out
);
   import aprc_pkg::*;

   logic [AGE_W-1:0]  age_ff, age_in;
   logic              ref_ff, ref_in;
   logic              occ_ff, occ_in;
   logic [PAGE_W-1:0] owner_ff;
   chain_type         chain_ff, chain_nx_in;
   logic              active, sel;

   assign active = {1'b0, cell_idx} < ctl.n_active;
   assign sel    = ctl.frame == cell_idx;

   always_comb begin
      age_in = age_ff;
      ref_in = ref_ff;
      occ_in = occ_ff;
      if (ctl.tick && active) begin
         age_in = {ref_ff, age_ff[AGE_W-1:1]};
         ref_in = 1'b0;
      end
      if (ctl.set_ref && sel) begin
         ref_in = 1'b1;
      end
      if (ctl.load && sel) begin
         occ_in = 1'b1;
         ref_in = 1'b1;
         if (ctl.zero_age) begin
            age_in = '0;
         end
      end
   end

   // First free frame wins; otherwise the first strictly smaller age.
   always_comb begin
      chain_nx_in = chain_in;
      if (!chain_in.found_free && active) begin
         if (!occ_ff) begin
            chain_nx_in.found_free = 1'b1;
            chain_nx_in.idx        = cell_idx;
         end else if ({1'b0, age_ff} < chain_in.age) begin
            chain_nx_in.idx   = cell_idx;
            chain_nx_in.age   = {1'b0, age_ff};
            chain_nx_in.owner = owner_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff   <= '0;
         ref_ff   <= 1'b0;
         occ_ff   <= 1'b0;
         chain_ff <= '0;
      end else begin
         age_ff   <= age_in;
         ref_ff   <= ref_in;
         occ_ff   <= occ_in;
         chain_ff <= chain_nx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load && sel) begin
         owner_ff <= ctl.page;
      end
   end

   assign chain_out = chain_ff;

endmodule

// ----- rtl/aging_page_replacement_core.sv -----
// Top level of the aging page replacement core: controller, page table memory
// and the row of frame cells. Depends on aprc_pkg and aprc_cell.
`timescale 1ns / 1ps
// After reset the core sweeps the 1024-entry page table clear, one entry per
// cycle, and takes no request until that is done; CSR writes are taken at any
// time. A request is one page reference. A hit goes through the table read
// with aging tick, the lookup and the response load before the next request
// is accepted. A miss waits for the victim search to ripple through the row
// of 64 frame cells, one cell per cycle. One request is handled at a time;
// the response register frees the controller, so the next request is
// accepted while the previous response still waits to be taken.
module aging_page_replacement_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [9:0]                      req_page_number,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_page_fault,
   output logic [5:0]                      rsp_frame_index,
   output logic                            rsp_evicted,
   output logic [9:0]                      rsp_evicted_page,
   output logic                            rsp_aging_done,
   output logic [31:0]                     rsp_fault_total,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [aprc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [aprc_pkg::CSR_DATA_W-1:0] csr_data
);
   import aprc_pkg::*;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [6:0]  frames_ff;
   logic [15:0] tick_ff;
   logic [COUNT_W-1:0] n_active;

   // Request bookkeeping.
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [15:0]        refs_ff, refs_in;
   logic [31:0]        faults_ff, faults_in;
   logic               aged_ff, aged_in;
   logic               fault_ff, fault_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic               evict_ff, evict_in;
   logic [PAGE_W-1:0]  evpage_ff, evpage_in;
   logic [COUNT_W-1:0] wait_ff, wait_in;
   logic [CLEAR_W-1:0] clr_ff, clr_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_load;

   // Page table memory: {present, frame}.
   logic [FRAME_W:0]   ptab [0:NUM_PAGES-1];
   logic               mem_we;
   logic [PAGE_W-1:0]  mem_waddr;
   logic [FRAME_W:0]   mem_wdata;
   logic [FRAME_W:0]   rdata_ff;
   logic               req_acc;

   cell_ctl_type       ctl;
   chain_type          chain [0:NUM_FRAMES];

   assign req_acc   = req_valid && req_ready;
   assign req_ready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;

   // Clamp the frame count to 1..NUM_FRAMES.
   always_comb begin
      if (frames_ff == '0) begin
         n_active = COUNT_W'(1);
      end else if ({1'b0, frames_ff} > 8'(NUM_FRAMES)) begin
         n_active = COUNT_W'(NUM_FRAMES);
      end else begin
         n_active = COUNT_W'(frames_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_RESET;
         tick_ff   <= TICK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAMES_IN_USE: frames_ff <= csr_data[6:0];
            CSR_TICK_INTERVAL: tick_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Controller: next state, bookkeeping and cell commands.
   always_comb begin
      state_in  = state_ff;
      page_in   = page_ff;
      refs_in   = refs_ff;
      faults_in = faults_ff;
      aged_in   = aged_ff;
      fault_in  = fault_ff;
      frame_in  = frame_ff;
      evict_in  = evict_ff;
      evpage_in = evpage_ff;
      wait_in   = wait_ff;
      clr_in    = clr_ff;
      mem_we    = 1'b0;
      mem_waddr = page_ff;
      mem_wdata = '0;
      rsp_load  = 1'b0;
      ctl          = '0;
      ctl.n_active = n_active;
      ctl.frame    = frame_ff;
      ctl.page     = page_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff[PAGE_W-1:0];
            clr_in    = clr_ff + CLEAR_W'(1);
            if (clr_ff == CLEAR_W'(NUM_PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               page_in   = req_page_number;
               fault_in  = 1'b0;
               evict_in  = 1'b0;
               evpage_in = '0;
               // Run a tick first once the interval has gone by.
               if (refs_ff >= tick_ff) begin
                  aged_in = 1'b1;
                  refs_in = 16'd1;
               end else begin
                  aged_in = 1'b0;
                  if (refs_ff != 16'hFFFF) begin
                     refs_in = refs_ff + 16'd1;
                  end
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            ctl.tick = aged_ff;
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (rdata_ff[FRAME_W]) begin
               // Hit: mark the frame referenced.
               frame_in    = rdata_ff[FRAME_W-1:0];
               ctl.set_ref = 1'b1;
               ctl.frame   = rdata_ff[FRAME_W-1:0];
               state_in    = ST_DONE;
            end else begin
               wait_in  = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // Hold until the search has rippled to the end of the row.
            wait_in = wait_ff + COUNT_W'(1);
            if (wait_ff == COUNT_W'(NUM_FRAMES)) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            frame_in     = chain[NUM_FRAMES].idx;
            evict_in     = !chain[NUM_FRAMES].found_free;
            evpage_in    = chain[NUM_FRAMES].found_free ? '0 : chain[NUM_FRAMES].owner;
            fault_in     = 1'b1;
            ctl.load     = 1'b1;
            ctl.zero_age = !chain[NUM_FRAMES].found_free;
            ctl.frame    = chain[NUM_FRAMES].idx;
            // Drop the displaced page from the table.
            mem_we    = !chain[NUM_FRAMES].found_free;
            mem_waddr = chain[NUM_FRAMES].owner;
            if (faults_ff != 32'hFFFF_FFFF) begin
               faults_in = faults_ff + 32'd1;
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = page_ff;
            mem_wdata = {1'b1, frame_ff};
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         refs_ff      <= '0;
         faults_ff    <= '0;
         wait_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         refs_ff      <= refs_in;
         faults_ff    <= faults_in;
         wait_ff      <= wait_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff   <= page_in;
      aged_ff   <= aged_in;
      fault_ff  <= fault_in;
      frame_ff  <= frame_in;
      evict_ff  <= evict_in;
      evpage_ff <= evpage_in;
      if (rsp_load) begin
         rsp_page_fault   <= fault_ff;
         rsp_frame_index  <= frame_ff;
         rsp_evicted      <= evict_ff;
         rsp_evicted_page <= evpage_ff;
         rsp_aging_done   <= aged_ff;
         rsp_fault_total  <= faults_ff;
      end
   end

   // Page table: one write port, registered read at request acceptance.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ptab[mem_waddr] <= mem_wdata;
      end
      if (req_acc) begin
         rdata_ff <= ptab[req_page_number];
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Row of frame cells; the head starts with no free frame and age 256.
   assign chain[0] = '{found_free: 1'b0, idx: '0, age: 9'd256, owner: '0};

   for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
      aprc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (FRAME_W'(g)),
         .ctl       (ctl),
         .chain_in  (chain[g]),
         .chain_out (chain[g+1])
      );
   end

   // At least one frame is active, so the search always ends on a candidate.
   a_place_candidate: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PLACE) |-> (chain[NUM_FRAMES].found_free || !chain[NUM_FRAMES].age[AGE_W]))
      else $error("victim search ended without a candidate");

   a_fault_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (faults_ff >= $past(faults_ff)))
      else $error("fault count went down");

   a_clear_writes_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (mem_we && mem_wdata == '0 && !rsp_valid_ff))
      else $error("clearing pass not writing zeros");

endmodule
